[rtl/label_bounding_box_tracker_unit_defines.svh]
// ----------------------------------------------------------------------------
// Label bounding box tracker - assertion macros
// Shared concurrent assertion forms used by the tracker's queue and table engine.
// ----------------------------------------------------------------------------
`ifndef LABEL_BOUNDING_BOX_TRACKER_UNIT_DEFINES_SVH
`define LABEL_BOUNDING_BOX_TRACKER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define LBBT_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define LBBT_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/lbbt_pkg.sv]
// ----------------------------------------------------------------------------
// Label bounding box tracker - package
// Field widths, opcodes and the command word passed from front to back.
// ----------------------------------------------------------------------------
package lbbt_pkg;

   localparam int LABEL_W      = 8;
   localparam int COORD_W      = 12;
   localparam int OP_W         = 2;
   localparam int CFG_WIDTH_W  = 13;
   localparam int COORD_LIMIT  = 4096;
   localparam int WIDTH_RESET  = 1024;
   localparam int QUEUE_DEPTH  = 4;

   localparam logic [OP_W-1:0] OP_PIXEL = 2'd0;
   localparam logic [OP_W-1:0] OP_READ  = 2'd1;
   localparam logic [OP_W-1:0] OP_FRAME = 2'd2;

   typedef enum logic [1:0] {
      CMD_PIXEL,
      CMD_READ,
      CMD_CLEAR
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type        kind;
      logic [LABEL_W-1:0]  label;
      logic [COORD_W-1:0]  x;
      logic [COORD_W-1:0]  y;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic [COORD_W-1:0] x_lo;
      logic [COORD_W-1:0] y_lo;
      logic [COORD_W-1:0] x_hi;
      logic [COORD_W-1:0] y_hi;
   } box_type;

endpackage

[rtl/lbbt_front.sv]
// ----------------------------------------------------------------------------
// Label bounding box tracker - front end
// Accepts request words, tracks the raster position and issues commands.
// ----------------------------------------------------------------------------
module lbbt_front #(
   parameter int MAX_DIM = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [lbbt_pkg::CFG_WIDTH_W-1:0]    csr_write_data,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [lbbt_pkg::OP_W-1:0]           req_op,
   input  logic [lbbt_pkg::LABEL_W-1:0]        req_label,
   input  lbbt_pkg::queue_status_type          q_status,
   output logic                                q_push,
   output lbbt_pkg::cmd_type                   q_cmd
);
   import lbbt_pkg::*;

   localparam int CAP_INT = (MAX_DIM > COORD_LIMIT) ? COORD_LIMIT : MAX_DIM;
   localparam logic [CFG_WIDTH_W-1:0] DIM_CAP = CFG_WIDTH_W'(CAP_INT);

   logic [CFG_WIDTH_W-1:0] width_ff;
   logic [COORD_W-1:0]     col_ff, col_in;
   logic [COORD_W-1:0]     row_ff, row_in;
   logic [CFG_WIDTH_W-1:0] line_w;
   logic [CFG_WIDTH_W-1:0] col_plus;
   logic [CFG_WIDTH_W-1:0] row_plus;
   logic                   accept;

   assign req_ready = !q_status.full;
   assign accept    = req_valid && req_ready;

   // Out-of-range widths are clamped to 1 and to the dimension cap.
   always_comb begin
      if (width_ff == '0) begin
         line_w = CFG_WIDTH_W'(1);
      end else if (width_ff > DIM_CAP) begin
         line_w = DIM_CAP;
      end else begin
         line_w = width_ff;
      end
   end

   assign col_plus = {1'b0, col_ff} + CFG_WIDTH_W'(1);
   assign row_plus = {1'b0, row_ff} + CFG_WIDTH_W'(1);

   always_comb begin
      q_push       = 1'b0;
      q_cmd.kind   = CMD_PIXEL;
      q_cmd.label  = req_label;
      q_cmd.x      = col_ff;
      q_cmd.y      = row_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      unique case (req_op)
         OP_PIXEL: begin
            q_push = accept;
            if (accept) begin
               if (col_plus >= line_w) begin
                  col_in = '0;
                  if (row_plus < DIM_CAP) begin
                     row_in = row_plus[COORD_W-1:0];
                  end
               end else begin
                  col_in = col_plus[COORD_W-1:0];
               end
            end
         end
         OP_READ: begin
            q_push     = accept;
            q_cmd.kind = CMD_READ;
         end
         OP_FRAME: begin
            q_push     = accept;
            q_cmd.kind = CMD_CLEAR;
            if (accept) begin
               col_in = '0;
               row_in = '0;
            end
         end
         default: begin
            // The unused opcode is consumed with no effect.
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= CFG_WIDTH_W'(WIDTH_RESET);
         col_ff   <= '0;
         row_ff   <= '0;
      end else begin
         if (csr_write_enable) begin
            width_ff <= csr_write_data;
         end
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

[rtl/lbbt_queue.sv]
// ----------------------------------------------------------------------------
// Label bounding box tracker - command queue
// Small FIFO that decouples the front end from the table update engine.
// ----------------------------------------------------------------------------
`include "label_bounding_box_tracker_unit_defines.svh"

module lbbt_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  lbbt_pkg::cmd_type           push_cmd,
   input  logic                        pop,
   output lbbt_pkg::cmd_type           head,
   output lbbt_pkg::queue_status_type  status
);
   import lbbt_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(QUEUE_DEPTH);

   cmd_type            slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign head         = slot_ff[rd_ptr_ff];
   assign status.full  = (count_ff == FULL_COUNT);
   assign status.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   `LBBT_ASSERT_NOW(a_no_push_when_full, clock, reset, push, !status.full, "push into full queue")
   `LBBT_ASSERT_NOW(a_no_pop_when_empty, clock, reset, pop, !status.empty, "pop from empty queue")
   `LBBT_ASSERT_NEXT(a_count_moves, clock, reset, push && !pop, count_ff == $past(count_ff) + CNT_W'(1), "push lost")

endmodule

[rtl/lbbt_back.sv]
// ----------------------------------------------------------------------------
// Label bounding box tracker - table engine
// Holds the box table and seen flags and executes queued commands.
// ----------------------------------------------------------------------------
`include "label_bounding_box_tracker_unit_defines.svh"

module lbbt_back #(
   parameter int LABEL_COUNT = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   input  lbbt_pkg::queue_status_type        q_status,
   input  lbbt_pkg::cmd_type                 q_head,
   output logic                              q_pop,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [lbbt_pkg::LABEL_W-1:0]      rsp_label_out,
   output logic                              rsp_present,
   output logic [lbbt_pkg::COORD_W-1:0]      rsp_min_x,
   output logic [lbbt_pkg::COORD_W-1:0]      rsp_min_y,
   output logic [lbbt_pkg::COORD_W-1:0]      rsp_max_x,
   output logic [lbbt_pkg::COORD_W-1:0]      rsp_max_y
);
   import lbbt_pkg::*;

   localparam int IDX_W = $clog2(LABEL_COUNT);
   localparam int CMP_W = LABEL_W + 1;
   localparam logic [CMP_W-1:0] LABEL_LIMIT = CMP_W'(LABEL_COUNT);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_REPLY
   } state_type;

   state_type             state_ff;
   logic [LABEL_COUNT-1:0] seen_ff;
   logic [LABEL_W-1:0]    label_ff;
   logic [COORD_W-1:0]    x_ff;
   logic [COORD_W-1:0]    y_ff;
   logic                  in_range_ff;
   box_type               rd_box_ff;
   box_type               box_mem [LABEL_COUNT];
   logic                  rsp_valid_ff;
   logic                  rsp_present_ff;
   logic [LABEL_W-1:0]    rsp_label_ff;
   box_type               rsp_box_ff;

   logic                  head_in_range;
   logic                  entry_seen;
   logic                  mem_wr;
   box_type               wr_box;

   assign head_in_range = ({1'b0, q_head.label} < LABEL_LIMIT);

   // A read may only leave the queue when the output register will be free.
   assign q_pop = (state_ff == ST_IDLE) && !q_status.empty &&
                  ((q_head.kind != CMD_READ) || !rsp_valid_ff || rsp_ready);

   assign entry_seen = in_range_ff && seen_ff[label_ff[IDX_W-1:0]];
   assign mem_wr     = (state_ff == ST_UPDATE);

   always_comb begin
      if (!entry_seen) begin
         wr_box.x_lo = x_ff;
         wr_box.y_lo = y_ff;
         wr_box.x_hi = x_ff;
         wr_box.y_hi = y_ff;
      end else begin
         wr_box.x_lo = (x_ff < rd_box_ff.x_lo) ? x_ff : rd_box_ff.x_lo;
         wr_box.y_lo = (y_ff < rd_box_ff.y_lo) ? y_ff : rd_box_ff.y_lo;
         wr_box.x_hi = (x_ff > rd_box_ff.x_hi) ? x_ff : rd_box_ff.x_hi;
         wr_box.y_hi = (y_ff > rd_box_ff.y_hi) ? y_ff : rd_box_ff.y_hi;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_wr) begin
         box_mem[label_ff[IDX_W-1:0]] <= wr_box;
      end
      if (q_pop) begin
         rd_box_ff <= box_mem[q_head.label[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (q_pop) begin
                  label_ff    <= q_head.label;
                  x_ff        <= q_head.x;
                  y_ff        <= q_head.y;
                  in_range_ff <= head_in_range;
                  unique case (q_head.kind)
                     CMD_PIXEL: begin
                        if (head_in_range) begin
                           state_ff <= ST_UPDATE;
                        end
                     end
                     CMD_READ: begin
                        state_ff <= ST_REPLY;
                     end
                     CMD_CLEAR: begin
                        seen_ff <= '0;
                     end
                     default: begin
                        state_ff <= ST_IDLE;
                     end
                  endcase
               end
            end
            ST_UPDATE: begin
               seen_ff[label_ff[IDX_W-1:0]] <= 1'b1;
               state_ff <= ST_IDLE;
            end
            ST_REPLY: begin
               rsp_valid_ff   <= 1'b1;
               rsp_label_ff   <= label_ff;
               rsp_present_ff <= entry_seen;
               rsp_box_ff     <= entry_seen ? rd_box_ff : '0;
               state_ff       <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_label_out = rsp_label_ff;
   assign rsp_present   = rsp_present_ff;
   assign rsp_min_x     = rsp_box_ff.x_lo;
   assign rsp_min_y     = rsp_box_ff.y_lo;
   assign rsp_max_x     = rsp_box_ff.x_hi;
   assign rsp_max_y     = rsp_box_ff.y_hi;

   `LBBT_ASSERT_NOW(a_reply_slot_free, clock, reset, state_ff == ST_REPLY, !rsp_valid_ff, "output register busy at reply")
   `LBBT_ASSERT_NEXT(a_clear_flags, clock, reset, q_pop && q_head.kind == CMD_CLEAR, seen_ff == '0, "seen flags not cleared")
   `LBBT_ASSERT_NOW(a_box_ordered, clock, reset, rsp_valid_ff && rsp_present_ff, (rsp_box_ff.x_lo <= rsp_box_ff.x_hi) && (rsp_box_ff.y_lo <= rsp_box_ff.y_hi), "reported box inverted")

endmodule

[rtl/label_bounding_box_tracker_unit.sv]
// ----------------------------------------------------------------------------
// Label bounding box tracker - top level
// Per-label bounding boxes over a raster stream of label pixels.
// ----------------------------------------------------------------------------
// The block takes one request word per clock while its four-entry command
// queue has room. Pixel words (op 0) are stamped with the current column and
// row, read words (op 1) ask for one label's box, and new-frame words (op 2)
// clear all seen flags and both position counters; op 3 is dropped. Behind
// the queue the table engine handles each in-range pixel and each read by
// reading the box table and then updating the entry or loading the reply,
// and a new-frame word in its idle state alone. It takes no new command
// until it is back in idle, so the box table's read-modify-write sets the
// pace. A read's answer sits in an output register until it is taken, and
// further pixel words keep flowing while it waits. The seen flags are
// flip-flops cleared at reset, so no clearing pass is needed. The image
// width register may only be written while the block is idle; a width of 0
// acts as 1, and widths above the dimension cap act as the cap.
// ----------------------------------------------------------------------------
module label_bounding_box_tracker_unit #(
   parameter int LABEL_COUNT = 256,
   parameter int MAX_DIM     = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [lbbt_pkg::CFG_WIDTH_W-1:0]    csr_write_data,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [lbbt_pkg::OP_W-1:0]           req_op,
   input  logic [lbbt_pkg::LABEL_W-1:0]        req_label,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [lbbt_pkg::LABEL_W-1:0]        rsp_label_out,
   output logic                                rsp_present,
   output logic [lbbt_pkg::COORD_W-1:0]        rsp_min_x,
   output logic [lbbt_pkg::COORD_W-1:0]        rsp_min_y,
   output logic [lbbt_pkg::COORD_W-1:0]        rsp_max_x,
   output logic [lbbt_pkg::COORD_W-1:0]        rsp_max_y
);
   import lbbt_pkg::*;

   // Command path between the front end and the table engine.
   queue_status_type q_status;
   logic             q_push;
   logic             q_pop;
   cmd_type          q_cmd;
   cmd_type          q_head;

   // The front end owns the width register and the raster counters, so
   // every pixel leaves it already carrying its coordinates.
   lbbt_front #(
      .MAX_DIM (MAX_DIM)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_label        (req_label),
      .q_status         (q_status),
      .q_push           (q_push),
      .q_cmd            (q_cmd)
   );

   // The queue keeps command order, so clears and reads land between the
   // same pixels as they did on the input.
   lbbt_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_cmd),
      .pop      (q_pop),
      .head     (q_head),
      .status   (q_status)
   );

   // The table engine holds the box memory and seen flags and drives the
   // response register.
   lbbt_back #(
      .LABEL_COUNT (LABEL_COUNT)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_status      (q_status),
      .q_head        (q_head),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_label_out (rsp_label_out),
      .rsp_present   (rsp_present),
      .rsp_min_x     (rsp_min_x),
      .rsp_min_y     (rsp_min_y),
      .rsp_max_x     (rsp_max_x),
      .rsp_max_y     (rsp_max_y)
   );

endmodule
